// ===== rtl/occ_pkg.sv =====
// ----------------------------------------------------------------------------
// occ_pkg
// Shared types and constants for the obstacle collision and clearance core.
// ----------------------------------------------------------------------------
package occ_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int MAX_OBSTACLES = 1024;
    localparam int COUNT_W       = 11;
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        COUNT_W'((MAX_OBSTACLES < 2047) ? MAX_OBSTACLES : 2047);
    localparam logic [30:0] RADIUS_RESET =
        31'((((64'd3) << FRAC_BITS) + 64'd5) / 64'd10);

    localparam logic MODE_VEHICLE  = 1'b0;
    localparam logic MODE_OBSTACLE = 1'b1;

    typedef enum logic [1:0] {
        KIND_SPHERE   = 2'd0,
        KIND_CYLINDER = 2'd1,
        KIND_BOX      = 2'd2,
        KIND_UNKNOWN  = 2'd3
    } kind_t;

    typedef struct packed {
        logic               mode;
        logic [1:0]         obstacle_kind;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [30:0]        obstacle_size;
        logic [30:0]        obstacle_height;
        logic [30:0]        half_x;
        logic [30:0]        half_y;
        logic [30:0]        half_z;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic               this_hit;
        logic               any_hit;
        logic signed [31:0] min_clr;
        logic               clearance_valid;
        logic [COUNT_W-1:0] obs_cnt;
        logic               last_out;
    } out_item_t;

    // classified job handed from front to back
    typedef struct packed {
        logic        vehicle;   // frame start
        logic [1:0]  kind;
        logic [33:0] dx;        // centre distance magnitudes
        logic [33:0] dy;
        logic [33:0] dz;
        logic [33:0] bx;        // box closest point magnitudes
        logic [33:0] by;
        logic [33:0] bz;
        logic        vert_ok;
        logic [30:0] size;
        logic        last;
    } job_t;

endpackage

// ===== rtl/occ_if.sv =====
// ----------------------------------------------------------------------------
// occ_in_if / occ_out_if
// Valid-ready channels for input and result items.
// ----------------------------------------------------------------------------
interface occ_in_if;
    import occ_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface occ_out_if;
    import occ_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/obstacle_collision_clearance_core.sv =====
// ----------------------------------------------------------------------------
// obstacle_collision_clearance_core
// Point versus sphere, cylinder and box collision test with frame aggregate.
//
//   channel   dir   handshake     payload
//   in_ch     in    valid/ready   in_item_t
//   out_ch    out   valid/ready   out_item_t
//   cfg       in    cfg_we        cfg_data (vehicle radius)
//
// In the back end a vehicle item goes straight to its result; an obstacle item
// runs one square root (sphere or unknown kind) or two (cylinder or box) on
// the bit-serial square root, one root bit a cycle; the queue registers each item ahead.
// A two-entry queue lets the front accept items while the back works. Reset
// clears position and aggregate and loads the radius with 0.3 m; a stalled
// result holds the back end until taken.
// ----------------------------------------------------------------------------
module obstacle_collision_clearance_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [30:0]    cfg_data,
    occ_in_if.sink         in_ch,
    occ_out_if.source      out_ch
);
    import occ_pkg::*;

    logic [30:0] radius_reg;
    logic        job_valid, job_ready;
    job_t        job_data;

    // radius register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RESET;
        else if (cfg_we)
            radius_reg <= cfg_data;
    end

    occ_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .vehicle_radius (radius_reg),
        .in_valid       (in_ch.valid),
        .in_ready       (in_ch.ready),
        .in_data        (in_ch.data),
        .job_valid      (job_valid),
        .job_ready      (job_ready),
        .job_data       (job_data)
    );

    occ_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .vehicle_radius (radius_reg),
        .job_valid      (job_valid),
        .job_ready      (job_ready),
        .job_data       (job_data),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .out_data       (out_ch.data)
    );

endmodule

// ===== rtl/occ_front.sv =====
// ----------------------------------------------------------------------------
// occ_front
// Accepts items, keeps the vehicle position, forms differences and box
// clamps and pushes one job per item into a two-entry queue.
// ----------------------------------------------------------------------------
module occ_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [30:0]           vehicle_radius,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  occ_pkg::in_item_t     in_data,
    output logic                  job_valid,
    input  logic                  job_ready,
    output occ_pkg::job_t         job_data
);
    import occ_pkg::*;

    logic signed [31:0] vx_reg, vy_reg, vz_reg;
    job_t               q_reg [2];
    logic               wp_reg, rp_reg;
    logic [1:0]         cnt_reg;
    job_t               job_new;
    logic               push, pop;

    // magnitude of a difference
    function automatic logic [33:0] absd(input logic signed [34:0] a,
                                         input logic signed [34:0] b);
        logic signed [34:0] d;
        d = a - b;
        return d[34] ? 34'(-d) : 34'(d);
    endfunction

    // clamp v into [c-h, c+h]
    function automatic logic signed [34:0] clampv(input logic signed [31:0] v,
                                                  input logic signed [31:0] c,
                                                  input logic [30:0] h);
        logic signed [34:0] lo, hi, r;
        lo = 35'(c) - 35'(signed'({1'b0, h}));
        hi = 35'(c) + 35'(signed'({1'b0, h}));
        r  = 35'(v);
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r;
    endfunction

    // job formation
    always_comb
    begin
        logic signed [34:0] z0, zt, vr;
        job_new         = '0;
        job_new.vehicle = (in_data.mode == MODE_VEHICLE);
        job_new.kind    = in_data.obstacle_kind;
        job_new.dx      = absd(35'(vx_reg), 35'(in_data.coord_x));
        job_new.dy      = absd(35'(vy_reg), 35'(in_data.coord_y));
        job_new.dz      = absd(35'(vz_reg), 35'(in_data.coord_z));
        job_new.bx      = absd(35'(vx_reg), clampv(vx_reg, in_data.coord_x, in_data.half_x));
        job_new.by      = absd(35'(vy_reg), clampv(vy_reg, in_data.coord_y, in_data.half_y));
        job_new.bz      = absd(35'(vz_reg), clampv(vz_reg, in_data.coord_z, in_data.half_z));
        vr = 35'(signed'({1'b0, vehicle_radius}));
        z0 = 35'(in_data.coord_z);
        zt = z0 + 35'(signed'({1'b0, in_data.obstacle_height}));
        job_new.vert_ok = (35'(vz_reg) + vr >= z0) && (35'(vz_reg) - vr <= zt);
        job_new.size    = in_data.obstacle_size;
        job_new.last    = in_data.last;
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop       = job_valid && job_ready;
    assign job_data  = q_reg[rp_reg];

    // vehicle position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_reg <= '0;
            vy_reg <= '0;
            vz_reg <= '0;
        end
        else if (push && in_data.mode == MODE_VEHICLE)
        begin
            vx_reg <= in_data.coord_x;
            vy_reg <= in_data.coord_y;
            vz_reg <= in_data.coord_z;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push) q_reg[wp_reg] <= job_new;
    end

endmodule

// ===== rtl/occ_back.sv =====
// ----------------------------------------------------------------------------
// occ_back
// Runs up to two sums of squares and square roots one bit a cycle,
// tests the hit, folds the frame aggregate and holds the result item.
// ----------------------------------------------------------------------------
module occ_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [30:0]           vehicle_radius,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  occ_pkg::job_t         job_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output occ_pkg::out_item_t    out_data
);
    import occ_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQ   = 6'b000010,
        ST_SUM  = 6'b000100,
        ST_ROOT = 6'b001000,
        ST_FOLD = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    job_t        job_reg;
    logic [1:0]  sel_reg;        // which distance is in work
    logic [2:0]  term_reg;       // which square is in work
    logic [67:0] sq_reg;
    logic [71:0] acc_reg;
    logic [35:0] root_reg;
    logic [37:0] rem_reg;
    logic [5:0]  bit_reg;
    logic [35:0] d3_reg, d2_reg, db_reg;
    logic        hit_seen_reg, best_valid_reg;
    logic signed [31:0] best_reg;
    logic [COUNT_W-1:0] cnt_reg;
    out_item_t   res_reg;

    logic [33:0] term_val;

    localparam logic [1:0] SEL_D3 = 2'd0;
    localparam logic [1:0] SEL_D2 = 2'd1;
    localparam logic [1:0] SEL_DB = 2'd2;

    // operand for the current square
    always_comb
    begin
        term_val = '0;
        unique case (sel_reg)
            SEL_D3, SEL_D2:
            begin
                unique case (term_reg)
                    3'd0:    term_val = job_reg.dx;
                    3'd1:    term_val = job_reg.dy;
                    default: term_val = job_reg.dz;
                endcase
            end
            default:
            begin
                unique case (term_reg)
                    3'd0:    term_val = job_reg.bx;
                    3'd1:    term_val = job_reg.by;
                    default: term_val = job_reg.bz;
                endcase
            end
        endcase
    end

    assign job_ready = state_reg == ST_IDLE;
    assign out_valid = state_reg == ST_OUT;
    assign out_data  = res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (job_valid) state_next = job_data.vehicle ? ST_OUT : ST_SQ;
            ST_SQ:   state_next = ST_SUM;
            ST_SUM:
            begin
                if (term_reg == 3'd2 || (sel_reg == SEL_D2 && term_reg == 3'd1))
                    state_next = ST_ROOT;
                else
                    state_next = ST_SQ;
            end
            ST_ROOT:
            begin
                if (bit_reg == 6'd0)
                begin
                    if ((sel_reg == SEL_D3 && job_reg.kind == KIND_CYLINDER) ||
                        (sel_reg == SEL_D3 && job_reg.kind == KIND_BOX))
                        state_next = ST_SQ;
                    else
                        state_next = ST_FOLD;
                end
            end
            ST_FOLD: state_next = ST_OUT;
            ST_OUT:  if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // squaring multiplier, registered
    always_ff @(posedge clk)
    begin
        sq_reg <= term_val * term_val;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        logic [39:0] rem_sh;
        logic [39:0] rem_try;
        logic [37:0] rem_new;
        logic [35:0] root_new;
        logic [31:0] lim;
        logic [37:0] sum_r;
        logic        hit;
        logic signed [38:0] clr;
        logic signed [31:0] clr_s;
        out_item_t   veh_res;
        // one digit of the square root: bring down two bits, try to subtract
        rem_sh  = {rem_reg, acc_reg[71:70]};
        rem_try = {2'b00, root_reg, 2'b01};
        if (rem_sh >= rem_try)
        begin
            rem_new  = 38'(rem_sh - rem_try);
            root_new = {root_reg[34:0], 1'b1};
        end
        else
        begin
            rem_new  = 38'(rem_sh);
            root_new = {root_reg[34:0], 1'b0};
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                job_reg  <= job_data;
                sel_reg  <= SEL_D3;
                term_reg <= 3'd0;
                acc_reg  <= '0;
            end
            ST_SUM:
            begin
                acc_reg  <= acc_reg + 72'(sq_reg);
                term_reg <= term_reg + 3'd1;
                root_reg <= '0;
                rem_reg  <= '0;
                bit_reg  <= 6'd35;
            end
            ST_ROOT:
            begin
                root_reg <= root_new;
                rem_reg  <= rem_new;
                if (bit_reg != 6'd0)
                begin
                    bit_reg <= bit_reg - 6'd1;
                    acc_reg <= acc_reg << 2;
                end
                else
                begin
                    unique case (sel_reg)
                        SEL_D3:  d3_reg <= root_new;
                        SEL_D2:  d2_reg <= root_new;
                        default: db_reg <= root_new;
                    endcase
                    sel_reg  <= (job_reg.kind == KIND_CYLINDER) ? SEL_D2 : SEL_DB;
                    term_reg <= 3'd0;
                    acc_reg  <= '0;
                end
            end
            default: ;
        endcase
        lim = 32'(vehicle_radius);
        sum_r = 38'(vehicle_radius) + 38'(job_reg.size);
        unique case (job_reg.kind)
            KIND_SPHERE:   hit = 38'(d3_reg) <= sum_r;
            KIND_CYLINDER: hit = (38'(d2_reg) <= sum_r) && job_reg.vert_ok;
            KIND_BOX:      hit = 36'(db_reg) <= 36'(lim);
            default:       hit = 1'b0;
        endcase
        clr = signed'(39'(d3_reg)) - signed'(39'(vehicle_radius))
              - signed'(39'(job_reg.size));
        if (clr > 39'sd2147483647)       clr_s = 32'sh7fffffff;
        else if (clr < -39'sd2147483648) clr_s = 32'sh80000000;
        else                             clr_s = 32'(clr);
        veh_res          = '0;
        veh_res.last_out = job_data.last;
        if (state_reg == ST_FOLD)
        begin
            res_reg.this_hit        <= hit;
            res_reg.any_hit         <= hit_seen_reg | hit;
            res_reg.min_clr         <= (!best_valid_reg || clr_s < best_reg) ? clr_s : best_reg;
            res_reg.clearance_valid <= 1'b1;
            res_reg.obs_cnt         <= (cnt_reg < COUNT_CAP) ? cnt_reg + 1'b1 : cnt_reg;
            res_reg.last_out        <= job_reg.last;
        end
        else if (state_reg == ST_IDLE && job_valid && job_data.vehicle)
        begin
            res_reg <= veh_res;
        end
    end

    // frame aggregate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_seen_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            best_reg       <= '0;
            cnt_reg        <= '0;
        end
        else if (state_reg == ST_OUT && out_ready)
        begin
            hit_seen_reg   <= res_reg.any_hit;
            best_valid_reg <= res_reg.clearance_valid;
            best_reg       <= res_reg.min_clr;
            cnt_reg        <= res_reg.obs_cnt;
        end
    end

endmodule

// ===== test/obstacle_collision_clearance_core_tb.sv =====
// ----------------------------------------------------------------------------
// obstacle_collision_clearance_core_tb
// Self-checking bench for the obstacle collision and clearance core: items
// are sent with random gaps, an in-bench predictor computes each result, and
// a checker compares every accepted result with the oldest expected one.
// ----------------------------------------------------------------------------
module obstacle_collision_clearance_core_tb;
    import occ_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [30:0] R_MAX = 31'h7FFF_FFFF;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [30:0] cfg_data;

    occ_in_if  in_ch ();
    occ_out_if out_ch ();

    obstacle_collision_clearance_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch.sink),
        .out_ch   (out_ch.source)
    );

    // predictor state
    logic [30:0]        radius;
    logic signed [31:0] veh_x, veh_y, veh_z;
    logic               hit_seen, best_valid;
    logic signed [31:0] best_clr;
    logic [10:0]        seen_count;

    out_item_t expected_results[$];
    int        mismatches;
    int        idle_cycles;
    int        stall_left;
    bit        idle_enable;

    // clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // floor square root of a sum of three squares of 34-bit magnitudes
    function automatic logic [35:0] floor_root(logic [33:0] a, logic [33:0] b,
                                               logic [33:0] c);
        logic [71:0] s;
        logic [71:0] t2;
        logic [35:0] r;
        logic [35:0] t;
        s = 72'(a) * 72'(a) + 72'(b) * 72'(b) + 72'(c) * 72'(c);
        r = '0;
        for (int i = 35; i >= 0; i--)
        begin
            t = r | (36'd1 << i);
            t2 = 72'(t) * 72'(t);
            if (t2 <= s)
                r = t;
        end
        return r;
    endfunction

    function automatic logic [33:0] mag_diff(logic signed [35:0] a,
                                             logic signed [35:0] b);
        return (a >= b) ? 34'(a - b) : 34'(b - a);
    endfunction

    function automatic logic signed [35:0] clamp(logic signed [35:0] v,
                                                 logic signed [35:0] lo,
                                                 logic signed [35:0] hi);
        logic signed [35:0] r;
        r = v;
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r;
    endfunction

    // collision predictor: updates frame state and returns the result item
    function automatic out_item_t predict_collision(in_item_t it);
        out_item_t          res;
        logic [33:0]        dx, dy, dz;
        logic [35:0]        d;
        logic signed [35:0] px, py, pz;
        logic signed [39:0] clr;
        logic signed [39:0] reach;
        logic               hit;
        hit = 1'b0;
        if (it.mode == MODE_VEHICLE)
        begin
            veh_x = it.coord_x;
            veh_y = it.coord_y;
            veh_z = it.coord_z;
            hit_seen = 1'b0;
            best_clr = '0;
            best_valid = 1'b0;
            seen_count = '0;
        end
        else
        begin
            dx = mag_diff(36'(veh_x), 36'(it.coord_x));
            dy = mag_diff(36'(veh_y), 36'(it.coord_y));
            dz = mag_diff(36'(veh_z), 36'(it.coord_z));
            d = floor_root(dx, dy, dz);
            reach = 40'(radius) + 40'(it.obstacle_size);
            case (kind_t'(it.obstacle_kind))
                KIND_SPHERE:
                    hit = 40'(d) <= reach;
                KIND_CYLINDER:
                    hit = (40'(floor_root(dx, dy, '0)) <= reach)
                        && (40'(veh_z) + signed'(40'(radius)) >= 40'(it.coord_z))
                        && (40'(veh_z) - signed'(40'(radius))
                            <= 40'(it.coord_z) + signed'(40'(it.obstacle_height)));
                KIND_BOX:
                begin
                    px = clamp(36'(veh_x), 36'(it.coord_x) - 36'(it.half_x),
                               36'(it.coord_x) + 36'(it.half_x));
                    py = clamp(36'(veh_y), 36'(it.coord_y) - 36'(it.half_y),
                               36'(it.coord_y) + 36'(it.half_y));
                    pz = clamp(36'(veh_z), 36'(it.coord_z) - 36'(it.half_z),
                               36'(it.coord_z) + 36'(it.half_z));
                    hit = 40'(floor_root(mag_diff(36'(veh_x), px),
                                         mag_diff(36'(veh_y), py),
                                         mag_diff(36'(veh_z), pz))) <= 40'(radius);
                end
                default:
                    hit = 1'b0;
            endcase
            // saturated clearance
            clr = 40'(d) - 40'(radius) - 40'(it.obstacle_size);
            if (clr > 40'(S_MAX)) clr = 40'(S_MAX);
            if (clr < 40'(S_MIN)) clr = 40'(S_MIN);
            if (!best_valid || 32'(clr) < best_clr)
                best_clr = 32'(clr);
            best_valid = 1'b1;
            if (hit) hit_seen = 1'b1;
            if (seen_count < COUNT_CAP) seen_count++;
        end
        res.this_hit = hit;
        res.any_hit = hit_seen;
        res.min_clr = best_valid ? best_clr : '0;
        res.clearance_valid = best_valid;
        res.obs_cnt = seen_count;
        res.last_out = it.last;
        return res;
    endfunction

    // random idle burst on the input, sometimes
    task automatic maybe_idle();
        if (idle_enable && $urandom_range(3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge clk);
        end
    endtask

    // send one item and record its expected result
    task automatic send_item(in_item_t it);
        out_item_t exp_item;
        maybe_idle();
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        exp_item = predict_collision(it);
        expected_results = {expected_results, exp_item};
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_radius(logic [30:0] r);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= r;
        @(posedge clk);
        cfg_we   <= 1'b0;
        radius = r;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return S_MIN;
            1: return S_MAX;
            2: return 32'($urandom);
            default: return 32'(int'($urandom_range(600000)) - 300000);
        endcase
    endfunction

    function automatic logic [30:0] rand_extent();
        case ($urandom_range(5))
            0: return R_MAX;
            1: return '0;
            2: return 31'($urandom);
            default: return 31'($urandom_range(200000));
        endcase
    endfunction

    function automatic in_item_t make_item(logic mode, kind_t kind,
                                           logic signed [31:0] x,
                                           logic signed [31:0] y,
                                           logic signed [31:0] z,
                                           logic [30:0] size, logic last);
        in_item_t it;
        it.mode = mode;
        it.obstacle_kind = kind;
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        it.obstacle_size = size;
        it.obstacle_height = rand_extent();
        it.half_x = rand_extent();
        it.half_y = rand_extent();
        it.half_z = rand_extent();
        it.last = last;
        return it;
    endfunction

    function automatic in_item_t rand_item(logic mode, logic last);
        return make_item(mode, kind_t'($urandom_range(3)), rand_coord(),
                         rand_coord(), rand_coord(), rand_extent(), last);
    endfunction

    // directed extremes, every kind, vehicle item and obstacle before vehicle
    task automatic test_directed();
        send_item(make_item(MODE_OBSTACLE, KIND_SPHERE, 32'sd1000, 32'sd0, 32'sd0,
                            31'd100, 1'b0));
        send_item(make_item(MODE_VEHICLE, KIND_SPHERE, 32'sd0, 32'sd0, 32'sd0,
                            31'd0, 1'b1));
        send_item(make_item(MODE_OBSTACLE, KIND_SPHERE, 32'sd19661, 32'sd0, 32'sd0,
                            31'd0, 1'b0));
        send_item(make_item(MODE_OBSTACLE, KIND_SPHERE, 32'sd19662, 32'sd0, 32'sd0,
                            31'd0, 1'b0));
        send_item(make_item(MODE_OBSTACLE, KIND_CYLINDER, 32'sd0, 32'sd0, 32'sd19661,
                            31'd10, 1'b0));
        send_item(make_item(MODE_OBSTACLE, KIND_BOX, 32'sd100000, 32'sd0, 32'sd0,
                            31'd0, 1'b0));
        send_item(make_item(MODE_OBSTACLE, KIND_UNKNOWN, 32'sd0, 32'sd0, 32'sd0,
                            31'd0, 1'b1));
        send_item(make_item(MODE_VEHICLE, KIND_UNKNOWN, S_MIN, S_MIN, S_MIN, R_MAX, 1'b0));
        send_item(make_item(MODE_OBSTACLE, KIND_SPHERE, S_MAX, S_MAX, S_MAX, 31'd0, 1'b0));
        send_item(make_item(MODE_OBSTACLE, KIND_CYLINDER, S_MAX, S_MAX, S_MAX,
                            R_MAX, 1'b0));
        send_item(make_item(MODE_OBSTACLE, KIND_BOX, S_MAX, S_MIN, S_MAX, R_MAX, 1'b0));
        send_item(make_item(MODE_OBSTACLE, KIND_UNKNOWN, S_MIN, S_MIN, S_MIN, R_MAX, 1'b1));
        send_item(make_item(MODE_VEHICLE, KIND_BOX, S_MAX, 32'sd0, S_MIN, 31'd0, 1'b0));
        send_item(make_item(MODE_OBSTACLE, KIND_BOX, S_MIN, 32'sd0, S_MAX, R_MAX, 1'b1));
    endtask

    // frames with random content; the vehicle item carries a random last flag
    task automatic test_random_frames(int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            len = $urandom_range(12);
            send_item(rand_item(MODE_VEHICLE, 1'($urandom_range(1))));
            sent++;
            for (int i = 0; i < len; i++)
            begin
                send_item(rand_item(MODE_OBSTACLE, i == len - 1));
                sent++;
            end
        end
    endtask

    // long frame past the obstacle count cap, short sizes of work
    task automatic test_count_saturation();
        send_item(rand_item(MODE_VEHICLE, 1'b0));
        for (int i = 0; i < int'(COUNT_CAP) + 6; i++)
            send_item(make_item(MODE_OBSTACLE, KIND_SPHERE, rand_coord(),
                                rand_coord(), rand_coord(), rand_extent(), 1'b0));
    endtask

    // result side: random stall bursts and checking
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (idle_enable && $urandom_range(5) == 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left = $urandom_range(6);
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        out_item_t exp_res;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: %p", out_ch.data);
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (out_ch.data !== exp_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p",
                                 exp_res, out_ch.data);
                end
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("obstacle_collision_clearance_core regression: fail");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        idle_enable = 1'b1;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        radius = RADIUS_RESET;
        veh_x = '0; veh_y = '0; veh_z = '0;
        hit_seen = 1'b0; best_valid = 1'b0; best_clr = '0; seen_count = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_radius('0);
        test_directed();
        write_radius(R_MAX);
        test_random_frames(120);
        write_radius(31'd65536);
        test_count_saturation();
        write_radius(31'd200000);
        test_random_frames(300);
        // sender hold-off until all results are back
        write_radius(31'($urandom));
        test_random_frames(150);
        idle_enable = 1'b0;
        write_radius(RADIUS_RESET);
        test_random_frames(150);
        wait_drained();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("obstacle_collision_clearance_core regression: pass");
        else
            $display("obstacle_collision_clearance_core regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/occ_pkg.sv
rtl/occ_if.sv
rtl/occ_front.sv
rtl/occ_back.sv
rtl/obstacle_collision_clearance_core.sv
test/obstacle_collision_clearance_core_tb.sv
